>>> rtl/core/stis_pkg.sv
// Shared types and constants for the sorted table interpolation search core.
// No dependencies; used by sorted_table_interpolation_search_core.
package stis_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned INDEX_W = 10;
    localparam int unsigned COUNT_W = 11;

    localparam logic OPC_LOAD   = 1'b0;
    localparam logic OPC_SEARCH = 1'b1;

    typedef struct packed {
        logic                      opcode;
        logic [INDEX_W-1:0]        entry_index;
        logic signed [VALUE_W-1:0] data_value;
    } cmd_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] found_index;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_LOW,
        ST_RD_HIGH,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_RD_POS,
        ST_CMP_POS
    } state_t;

endpackage

>>> rtl/core/sorted_table_interpolation_search_core.sv
// Sorted table with interpolation search: table memory, sequencer and one
// shared add/subtract unit for the serial multiply and divide.
// Depends on stis_pkg.
//
// A load item (start with opcode LOAD) writes one table entry in the cycle it
// is accepted; busy does not rise and no result follows. A search item on a
// non-empty table raises busy until its result, which appears on result for
// exactly one cycle with result_valid high; the receiver cannot stall it, so
// it must take it then. Each probe first reads both window bounds and checks
// them in ST_RD_LOW, ST_RD_HIGH and ST_CHECK; a probe stops there if the
// target lies outside the window's values or the values at both bounds are
// equal. A probe that interpolates goes on with ceil(log2(TABLE_DEPTH))
// shift-add steps for the interpolation product, as many restoring divide
// steps, all on the one shared adder, a read at the probed position and one
// compare there; an interpolating probe thus makes three reads of the table
// with registered read data. result_valid rises at the edge that ends the last
// probe; with an empty table no probe runs and busy does not rise. The user
// must write the entry_count register only while busy is low and no result is
// pending; the block itself does not enforce it.
module sorted_table_interpolation_search_core #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  stis_pkg::cmd_t                     cmd,
    output logic                               result_valid,
    output stis_pkg::result_t                  result,
    input  logic                               cfg_wr_en,
    input  logic [stis_pkg::COUNT_W-1:0]       cfg_wr_data
);

    localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned POS_W  = IDX_W + 2;
    localparam int unsigned PROD_W = stis_pkg::VALUE_W + IDX_W;
    localparam int unsigned STEP_W = $clog2(IDX_W + 1);
    localparam logic signed [POS_W-1:0] POS_ONE = POS_W'(1);

    logic signed [stis_pkg::VALUE_W-1:0] mem [TABLE_DEPTH];
    logic signed [stis_pkg::VALUE_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]                    rd_addr;
    logic                                mem_we;

    stis_pkg::state_t state_reg, state_next;
    logic [stis_pkg::COUNT_W-1:0] entry_count_reg;
    logic result_valid_reg, result_valid_next;
    stis_pkg::result_t result_reg, result_next;

    logic signed [stis_pkg::VALUE_W-1:0] target_reg, target_next;
    logic signed [stis_pkg::VALUE_W-1:0] vlow_reg, vlow_next;
    logic signed [POS_W-1:0] low_reg, low_next;
    logic signed [POS_W-1:0] high_reg, high_next;
    logic signed [POS_W-1:0] pos_reg, pos_next;
    logic [PROD_W-1:0] work_reg, work_next;
    logic [PROD_W-1:0] mcand_reg, mcand_next;
    logic [PROD_W-1:0] dsh_reg, dsh_next;
    logic [IDX_W-1:0]  mplier_reg, mplier_next;
    logic [IDX_W-1:0]  quot_reg, quot_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // shared adder
    logic [PROD_W-1:0] alu_a, alu_b;
    logic              alu_cin;
    logic [PROD_W:0]   alu_sum;

    logic signed [POS_W-1:0] count_sat;
    logic [stis_pkg::VALUE_W:0] t_minus_lo;
    logic [stis_pkg::VALUE_W:0] hi_minus_lo;
    logic [POS_W-1:0]           span;
    logic [IDX_W-1:0]           quot_step;
    logic signed [POS_W-1:0]    pos_inc, pos_dec;

    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + {{PROD_W{1'b0}}, alu_cin};

    assign count_sat = (32'(entry_count_reg) > 32'(TABLE_DEPTH)) ? POS_W'(TABLE_DEPTH)
                                                                  : POS_W'(entry_count_reg);
    assign t_minus_lo  = {target_reg[stis_pkg::VALUE_W-1], target_reg}
                       - {vlow_reg[stis_pkg::VALUE_W-1], vlow_reg};
    assign hi_minus_lo = {rd_data_reg[stis_pkg::VALUE_W-1], rd_data_reg}
                       - {vlow_reg[stis_pkg::VALUE_W-1], vlow_reg};
    assign span        = high_reg - low_reg;
    assign quot_step   = IDX_W'({quot_reg, alu_sum[PROD_W]});
    assign pos_inc     = pos_reg + POS_ONE;
    assign pos_dec     = pos_reg - POS_ONE;

    assign busy         = (state_reg != stis_pkg::ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign mem_we = start && !busy && (cmd.opcode == stis_pkg::OPC_LOAD)
                 && (32'(cmd.entry_index) < 32'(TABLE_DEPTH));

    always_comb
    begin
        unique case (state_reg)
            stis_pkg::ST_RD_HIGH: rd_addr = high_reg[IDX_W-1:0];
            stis_pkg::ST_RD_POS:  rd_addr = pos_reg[IDX_W-1:0];
            default:              rd_addr = low_reg[IDX_W-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[IDX_W'(cmd.entry_index)] <= cmd.data_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        target_next       = target_reg;
        vlow_next         = vlow_reg;
        low_next          = low_reg;
        high_next         = high_reg;
        pos_next          = pos_reg;
        work_next         = work_reg;
        mcand_next        = mcand_reg;
        dsh_next          = dsh_reg;
        mplier_next       = mplier_reg;
        quot_next         = quot_reg;
        step_next         = step_reg;
        alu_a             = work_reg;
        alu_b             = '0;
        alu_cin           = 1'b0;

        unique case (state_reg)
            stis_pkg::ST_IDLE:
            begin
                if (start && cmd.opcode == stis_pkg::OPC_SEARCH)
                begin
                    target_next = cmd.data_value;
                    low_next    = '0;
                    high_next   = count_sat - POS_ONE;
                    if (count_sat == '0)
                    begin
                        result_valid_next = 1'b1;
                        result_next       = '0;
                    end
                    else
                    begin
                        state_next = stis_pkg::ST_RD_LOW;
                    end
                end
            end
            stis_pkg::ST_RD_LOW:
            begin
                state_next = stis_pkg::ST_RD_HIGH;
            end
            stis_pkg::ST_RD_HIGH:
            begin
                vlow_next  = rd_data_reg;
                state_next = stis_pkg::ST_CHECK;
            end
            stis_pkg::ST_CHECK:
            begin
                // rd_data_reg holds the value at the high bound
                if (target_reg < vlow_reg || target_reg > rd_data_reg)
                begin
                    result_valid_next = 1'b1;
                    result_next       = '0;
                    state_next        = stis_pkg::ST_IDLE;
                end
                else if (vlow_reg == rd_data_reg)
                begin
                    result_valid_next       = 1'b1;
                    result_next.found       = 1'b1;
                    result_next.found_index = stis_pkg::INDEX_W'(low_reg[IDX_W-1:0]);
                    state_next              = stis_pkg::ST_IDLE;
                end
                else
                begin
                    work_next   = '0;
                    mcand_next  = PROD_W'(t_minus_lo[stis_pkg::VALUE_W-1:0]);
                    mplier_next = span[IDX_W-1:0];
                    dsh_next    = PROD_W'(hi_minus_lo[stis_pkg::VALUE_W-1:0]) << (IDX_W - 1);
                    step_next   = STEP_W'(IDX_W - 1);
                    state_next  = stis_pkg::ST_MUL;
                end
            end
            stis_pkg::ST_MUL:
            begin
                // shift-add, multiplier bit 0 first
                alu_b       = mplier_reg[0] ? mcand_reg : '0;
                work_next   = alu_sum[PROD_W-1:0];
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    quot_next  = '0;
                    step_next  = STEP_W'(IDX_W - 1);
                    state_next = stis_pkg::ST_DIV;
                end
            end
            stis_pkg::ST_DIV:
            begin
                // restoring divide; quotient is known to fit IDX_W bits
                alu_b     = ~dsh_reg;
                alu_cin   = 1'b1;
                if (alu_sum[PROD_W])
                begin
                    work_next = alu_sum[PROD_W-1:0];
                end
                quot_next = quot_step;
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    pos_next   = low_reg + $signed({2'b00, quot_step});
                    state_next = stis_pkg::ST_RD_POS;
                end
            end
            stis_pkg::ST_RD_POS:
            begin
                state_next = stis_pkg::ST_CMP_POS;
            end
            stis_pkg::ST_CMP_POS:
            begin
                if (rd_data_reg == target_reg)
                begin
                    result_valid_next       = 1'b1;
                    result_next.found       = 1'b1;
                    result_next.found_index = stis_pkg::INDEX_W'(pos_reg[IDX_W-1:0]);
                    state_next              = stis_pkg::ST_IDLE;
                end
                else
                begin
                    if (rd_data_reg < target_reg)
                    begin
                        low_next = pos_inc;
                    end
                    else
                    begin
                        high_next = pos_dec;
                    end
                    if (rd_data_reg < target_reg ? (pos_inc <= high_reg) : (low_reg <= pos_dec))
                    begin
                        state_next = stis_pkg::ST_RD_LOW;
                    end
                    else
                    begin
                        result_valid_next = 1'b1;
                        result_next       = '0;
                        state_next        = stis_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = stis_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= stis_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
            entry_count_reg  <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            if (cfg_wr_en)
            begin
                entry_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        target_reg <= target_next;
        vlow_reg   <= vlow_next;
        low_reg    <= low_next;
        high_reg   <= high_next;
        pos_reg    <= pos_next;
        work_reg   <= work_next;
        mcand_reg  <= mcand_next;
        dsh_reg    <= dsh_next;
        mplier_reg <= mplier_next;
        quot_reg   <= quot_next;
        step_reg   <= step_next;
    end

endmodule
